// ----- rtl/gsp_pkg.sv -----
// Shared types, constants and the button remap for the gamepad serial poller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gsp_pkg;

  localparam int BITS_PER_READ = 16;
  localparam int BIT_CNT_W     = $clog2(BITS_PER_READ) + 1;
  localparam int TICK_W        = 9;
  localparam int HALF_W        = 8;
  localparam int POLL_W        = 24;
  localparam int CFG_W         = 24;
  localparam int CFG_IDX_W     = 1;
  localparam int BTN_W         = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 1'b1;

  localparam logic [HALF_W-1:0] HALF_PERIOD_RST   = 8'd6;
  localparam logic [POLL_W-1:0] POLL_INTERVAL_RST = 24'd16000;
  localparam logic [POLL_W-1:0] POLL_TIMER_MAX    = 24'hFFFFFF;

  // button word bit positions
  localparam int BTN_UP    = 3;
  localparam int BTN_DOWN  = 4;
  localparam int BTN_LEFT  = 5;
  localparam int BTN_RIGHT = 6;

  typedef enum logic [2:0] {
    PH_WAIT     = 3'd0,
    PH_LATCH    = 3'd1,
    PH_SETTLE   = 3'd2,
    PH_CLK_LOW  = 3'd3,
    PH_CLK_HIGH = 3'd4
  } phase_t;

  typedef struct packed {
    logic             latch_out;
    logic             clock_out;
    logic [BTN_W-1:0] buttons;
    logic             fresh;
  } res_t;

  // Invert the active-low raw word, remap it, cancel opposite directions, clear if absent.
  // Raw B and Y land on bits 9 and 10; raw Y also hits bit 0, where the
  // present flag already sits.
  function automatic logic [BTN_W-1:0] make_word(input logic [BITS_PER_READ-1:0] raw,
                                                 input logic present);
    logic [BITS_PER_READ-1:0] x;
    logic [BTN_W-1:0]         w;
    x = ~raw;
    w = 13'd1
      | (BTN_W'(x >> 1) & 13'd511)
      | (BTN_W'(x << 9) & 13'd1536)
      | (BTN_W'(x << 1) & 13'd6144);
    if (w[BTN_UP] && w[BTN_DOWN]) begin
      w[BTN_UP]   = 1'b0;
      w[BTN_DOWN] = 1'b0;
    end
    if (w[BTN_LEFT] && w[BTN_RIGHT]) begin
      w[BTN_LEFT]  = 1'b0;
      w[BTN_RIGHT] = 1'b0;
    end
    if (!present) begin
      w = '0;
    end
    return w;
  endfunction

endpackage

// ----- rtl/gsp_sequencer.sv -----
// Poll sequencer: config registers, phase/tick/bit counters, shift register
// and published button word. One step per accepted tick. Uses gsp_pkg.
`timescale 1ns / 1ps

module gsp_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsp_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           step,
  input  logic                           data_line,
  output gsp_pkg::res_t                  res
);
  import gsp_pkg::*;

  logic [HALF_W-1:0]        half_period;
  logic [POLL_W-1:0]        poll_interval;

  phase_t                   phase, phase_next;
  logic [TICK_W-1:0]        tick_count, tick_count_next;
  logic [BIT_CNT_W-1:0]     bit_count, bit_count_next;
  logic [BITS_PER_READ-1:0] shift_word, shift_word_next;
  logic                     present_flag, present_flag_next;
  logic [BTN_W-1:0]         button_word, button_word_next;
  logic [POLL_W-1:0]        poll_timer, poll_timer_next;
  logic                     fresh_next;

  logic [HALF_W-1:0]        half;
  logic [TICK_W-1:0]        tick_inc;
  logic [BIT_CNT_W-1:0]     bit_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period   <= HALF_PERIOD_RST;
      poll_interval <= POLL_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_PERIOD:   half_period   <= cfg_data[HALF_W-1:0];
        REG_POLL_INTERVAL: poll_interval <= cfg_data[POLL_W-1:0];
        default: ;
      endcase
    end
  end

  // zero half period acts as one tick
  assign half     = (half_period == '0) ? HALF_W'(1) : half_period;
  assign tick_inc = tick_count + TICK_W'(1);
  assign bit_inc  = bit_count + BIT_CNT_W'(1);

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    bit_count_next    = bit_count;
    shift_word_next   = shift_word;
    present_flag_next = present_flag;
    button_word_next  = button_word;
    poll_timer_next   = poll_timer;
    fresh_next        = 1'b0;
    case (phase)
      PH_LATCH: begin
        tick_count_next = tick_inc;
        if (tick_inc >= {half, 1'b0}) begin
          phase_next      = PH_SETTLE;
          tick_count_next = '0;
        end
      end
      PH_SETTLE: begin
        tick_count_next = tick_inc;
        if (tick_inc >= {1'b0, half}) begin
          phase_next      = PH_CLK_LOW;
          tick_count_next = '0;
        end
      end
      PH_CLK_LOW: begin
        tick_count_next = tick_inc;
        if (tick_inc >= {1'b0, half}) begin
          shift_word_next = {data_line, shift_word[BITS_PER_READ-1:1]};
          phase_next      = PH_CLK_HIGH;
          tick_count_next = '0;
        end
      end
      PH_CLK_HIGH: begin
        tick_count_next = tick_inc;
        if (tick_inc >= {1'b0, half}) begin
          tick_count_next = '0;
          bit_count_next  = bit_inc;
          if (bit_inc >= BIT_CNT_W'(BITS_PER_READ)) begin
            button_word_next = make_word(shift_word, present_flag);
            fresh_next       = 1'b1;
            bit_count_next   = '0;
            poll_timer_next  = '0;
            phase_next       = PH_WAIT;
          end else begin
            phase_next = PH_CLK_LOW;
          end
        end
      end
      default: begin
        // wait phase, also recovers from any unused code
        phase_next = PH_WAIT;
        if (poll_timer >= poll_interval) begin
          present_flag_next = ~data_line;
          shift_word_next   = '0;
          bit_count_next    = '0;
          tick_count_next   = '0;
          phase_next        = PH_LATCH;
        end else if (poll_timer != POLL_TIMER_MAX) begin
          poll_timer_next = poll_timer + POLL_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT;
      tick_count   <= '0;
      bit_count    <= '0;
      shift_word   <= '0;
      present_flag <= 1'b0;
      button_word  <= '0;
      poll_timer   <= '0;
    end else if (step) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      bit_count    <= bit_count_next;
      shift_word   <= shift_word_next;
      present_flag <= present_flag_next;
      button_word  <= button_word_next;
      poll_timer   <= poll_timer_next;
    end
  end

  always_comb begin
    res.latch_out = (phase_next == PH_LATCH);
    res.clock_out = (phase_next != PH_CLK_LOW);
    res.buttons   = button_word_next;
    res.fresh     = fresh_next;
  end

endmodule

// ----- rtl/gsp_out_buf.sv -----
// Two-entry output buffer: head register drives the result port, a skid
// entry catches one beat while the receiver stalls. Uses gsp_pkg.
`timescale 1ns / 1ps

module gsp_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gsp_pkg::res_t push_data,
  output logic          full,
  output logic          head_valid,
  output gsp_pkg::res_t head,
  input  logic          head_stall
);
  import gsp_pkg::*;

  logic tail_valid;
  res_t tail;
  logic pop;

  assign pop  = head_valid && !head_stall;
  assign full = tail_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (tail_valid) begin
          tail_valid <= push;
        end else begin
          head_valid <= push;
        end
      end else if (push) begin
        if (head_valid) begin
          tail_valid <= 1'b1;
        end else begin
          head_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (tail_valid) begin
        head <= tail;
        tail <= push_data;
      end else begin
        head <= push_data;
      end
    end else if (push) begin
      if (head_valid) begin
        tail <= push_data;
      end else begin
        head <= push_data;
      end
    end
  end

endmodule

// ----- rtl/gamepad_serial_poller.sv -----
// Top level of the gamepad serial poller: sequencer plus output buffer.
// Depends on gsp_pkg, gsp_sequencer and gsp_out_buf.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_stall, data_line): one beat per time-base tick,
//   carrying the sampled pad data line. Output channel (out_valid/out_stall):
//   one beat per input beat with the latch and clock line levels to drive,
//   the last published button word and a fresh flag on the tick a new word
//   is published. Once the poll interval has elapsed, a poll runs the latch,
//   settle and clock phases, shifting in the 16-bit raw word bit by bit.
//   Config port (cfg_we, cfg_index, cfg_data): index 0 half period in ticks,
//   index 1 poll interval in ticks; write only while no beats are in flight.
//   An accepted beat is registered into the output head, or into the skid
//   entry behind a stalled head. Throughput: one beat per cycle while in_stall
//   is low, set by the single registered step of the sequencer counters.
//   Receiver stall: a two-entry output buffer absorbs one extra beat, then
//   in_stall rises until the head drains.
//   Reset: synchronous, clears all counters, the button word, the buffer and
//   restores the config registers to their defaults (6 and 16000).
module gamepad_serial_poller (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsp_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           data_line,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           latch_out,
  output logic                           clock_out,
  output logic [gsp_pkg::BTN_W-1:0]      buttons,
  output logic                           fresh
);
  import gsp_pkg::*;

  logic step;
  logic buf_full;
  res_t res;
  res_t head;

  assign in_stall = buf_full;
  assign step     = in_valid && !buf_full;

  gsp_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .data_line (data_line),
    .res       (res)
  );

  gsp_out_buf u_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .push_data  (res),
    .full       (buf_full),
    .head_valid (out_valid),
    .head       (head),
    .head_stall (out_stall)
  );

  assign latch_out = head.latch_out;
  assign clock_out = head.clock_out;
  assign buttons   = head.buttons;
  assign fresh     = head.fresh;

`ifndef SYNTHESIS
  // skid entry only fills behind a valid head
  a_stall_has_head: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("stall raised with empty output head");

  // latch pulse never overlaps a low clock
  a_latch_clock_high: assert property (@(posedge clk) disable iff (rst)
    (out_valid && latch_out) |-> clock_out)
    else $error("latch high while clock low");

  // a word is published only at the end of a clock-high half period
  a_fresh_idle_lines: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fresh) |-> (clock_out && !latch_out))
    else $error("fresh word outside wait phase");

  // after an accepted beat the output head is valid in the next cycle
  a_accept_fills_head: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted beat not visible at output");
`endif

endmodule

// ----- bench/tb_gamepad_serial_poller.sv -----
// Self-checking bench for gamepad_serial_poller: directed table of polls, then random polls.
// Uses its own beat-by-beat predictor of the poll sequencer to check every output beat.
// Depends on gsp_pkg and the gamepad_serial_poller RTL.
`timescale 1ns / 1ps

module tb_gamepad_serial_poller;
  import gsp_pkg::*;

  localparam int     RAND_ITEMS  = 1000;
  localparam int     MAX_GAP     = 17;
  localparam int     LONG_HOLD   = 400;
  localparam int     DIR_ROWS    = 21;
  localparam longint CYCLE_LIMIT = 2_000_000;

  typedef enum logic [1:0] {ROW_CFG, ROW_POLL, ROW_TICKS} row_kind_t;

  // ROW_CFG: a = register, b = value. ROW_POLL: a = raw word, b = present.
  // ROW_TICKS: a = count, b = data line. want < 0: predictor check only.
  typedef struct packed {
    row_kind_t kind;
    int        a;
    int        b;
    int        want;
  } dir_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 data_line = 1'b0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 latch_out;
  logic                 clock_out;
  logic [BTN_W-1:0]     buttons;
  logic                 fresh;

  // predictor state
  logic [HALF_W-1:0]        seq_half;
  logic [POLL_W-1:0]        seq_interval;
  phase_t                   seq_ph;
  logic [TICK_W-1:0]        seq_tick;
  logic [4:0]               seq_bits;
  logic [BITS_PER_READ-1:0] seq_shift;
  logic                     seq_present;
  logic [BTN_W-1:0]         seq_word;
  logic [POLL_W-1:0]        seq_timer;

  res_t             due_q[$];
  res_t             last_res;
  logic [BTN_W-1:0] last_btn = '0;
  int               errs     = 0;
  int               n_items  = 0;
  longint           cycles   = 0;
  bit               no_idle  = 1'b0;
  bit               hold_req = 1'b0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_TICKS, 6, 1, 0},                            // after reset: still waiting
    '{ROW_CFG, int'(REG_HALF_PERIOD), 1, -1},
    '{ROW_CFG, int'(REG_POLL_INTERVAL), 0, -1},       // poll right away
    '{ROW_POLL, 'hFFFF, 1, 1},                        // nothing pressed
    '{ROW_POLL, 'h0000, 1, 8071},                     // all pressed, both pairs cancel
    '{ROW_POLL, 'h0000, 0, 0},                        // no pad
    '{ROW_POLL, 'hFFFF, 0, 0},
    '{ROW_CFG, int'(REG_HALF_PERIOD), 0, -1},         // zero half period
    '{ROW_POLL, 'hFFCF, 1, 1},                        // up + down
    '{ROW_POLL, 'hFF3F, 1, 1},                        // left + right
    '{ROW_POLL, 'hFFFE, 1, 513},                      // raw bit 0 remapped to bit 9
    '{ROW_POLL, 'hFFFD, 1, 1025},                     // raw bit 1 lands twice
    '{ROW_POLL, 'hFBFF, 1, 2049},
    '{ROW_POLL, 'hFFEF, 1, 9},                        // up alone
    '{ROW_CFG, int'(REG_HALF_PERIOD), 2, -1},
    '{ROW_CFG, int'(REG_POLL_INTERVAL), 3, -1},
    '{ROW_POLL, 'h5A5A, 1, -1},
    '{ROW_TICKS, 25, 0, -1},                          // leaves a poll in progress
    '{ROW_CFG, int'(REG_HALF_PERIOD), 255, -1},       // changed mid-poll
    '{ROW_CFG, int'(REG_POLL_INTERVAL), 'hFFFFFF, -1},
    '{ROW_TICKS, 20, 1, -1}
  };

  gamepad_serial_poller u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_line (data_line),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .latch_out (latch_out),
    .clock_out (clock_out),
    .buttons   (buttons),
    .fresh     (fresh)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // active-low raw word -> button word, present flag in bit 0
  function automatic logic [BTN_W-1:0] pad_word(input logic [BITS_PER_READ-1:0] raw,
                                                input logic here);
    logic [BITS_PER_READ-1:0] x;
    logic [BTN_W-1:0]         w;
    x = ~raw;
    w = {x[11], x[10], x[1], x[0], x[9:2], 1'b1};
    if (w[BTN_UP] && w[BTN_DOWN]) begin
      w[BTN_UP]   = 1'b0;
      w[BTN_DOWN] = 1'b0;
    end
    if (w[BTN_LEFT] && w[BTN_RIGHT]) begin
      w[BTN_LEFT]  = 1'b0;
      w[BTN_RIGHT] = 1'b0;
    end
    return here ? w : '0;
  endfunction

  function automatic void seq_reset();
    seq_half     = HALF_PERIOD_RST;
    seq_interval = POLL_INTERVAL_RST;
    seq_ph       = PH_WAIT;
    seq_tick     = '0;
    seq_bits     = '0;
    seq_shift    = '0;
    seq_present  = 1'b0;
    seq_word     = '0;
    seq_timer    = '0;
  endfunction

  // one time-base tick of the poll sequencer
  function automatic res_t poll_step(input logic d);
    int   half;
    res_t r;
    half    = (seq_half == 0) ? 1 : int'(seq_half);
    r.fresh = 1'b0;
    case (seq_ph)
      PH_LATCH: begin
        seq_tick = seq_tick + 1'b1;
        if (seq_tick >= 2 * half) begin
          seq_ph   = PH_SETTLE;
          seq_tick = '0;
        end
      end
      PH_SETTLE: begin
        seq_tick = seq_tick + 1'b1;
        if (seq_tick >= half) begin
          seq_ph   = PH_CLK_LOW;
          seq_tick = '0;
        end
      end
      PH_CLK_LOW: begin
        seq_tick = seq_tick + 1'b1;
        if (seq_tick >= half) begin
          seq_shift = {d, seq_shift[BITS_PER_READ-1:1]};
          seq_ph    = PH_CLK_HIGH;
          seq_tick  = '0;
        end
      end
      PH_CLK_HIGH: begin
        seq_tick = seq_tick + 1'b1;
        if (seq_tick >= half) begin
          seq_tick = '0;
          seq_bits = seq_bits + 1'b1;
          if (seq_bits >= BITS_PER_READ) begin
            seq_word  = pad_word(seq_shift, seq_present);
            r.fresh   = 1'b1;
            seq_bits  = '0;
            seq_timer = '0;
            seq_ph    = PH_WAIT;
          end else begin
            seq_ph = PH_CLK_LOW;
          end
        end
      end
      default: begin
        seq_ph = PH_WAIT;
        if (seq_timer >= seq_interval) begin
          seq_present = ~d;
          seq_shift   = '0;
          seq_bits    = '0;
          seq_tick    = '0;
          seq_ph      = PH_LATCH;
        end else if (seq_timer != POLL_TIMER_MAX) begin
          seq_timer = seq_timer + 1'b1;
        end
      end
    endcase
    r.latch_out = (seq_ph == PH_LATCH);
    r.clock_out = (seq_ph != PH_CLK_LOW);
    r.buttons   = seq_word;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      errs++;
    end
  endfunction

  // one input beat, after a random gap
  task automatic send_tick(input logic d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_line <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_res = poll_step(d);
    due_q.push_back(last_res);
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HALF_PERIOD) begin
      seq_half = val[HALF_W-1:0];
    end else begin
      seq_interval = val[POLL_W-1:0];
    end
  endtask

  // behave like a pad: presence while waiting, then the raw word bit by bit
  task automatic run_poll(input logic [BITS_PER_READ-1:0] raw, input logic here);
    logic d;
    do begin
      d = (seq_ph == PH_WAIT) ? ~here : raw[seq_bits[3:0]];
      send_tick(d);
    end while (!last_res.fresh);
  endtask

  task automatic run_noise(input int n);
    repeat (n) send_tick(1'($urandom_range(0, 1)));
  endtask

  initial begin : result_side
    int   hold;
    res_t want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold     = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (due_q.size() == 0) begin
        $error("output beat with nothing expected");
        errs++;
      end else begin
        want = due_q.pop_front();
        check_field("latch_out", 16'(want.latch_out), 16'(latch_out));
        check_field("clock_out", 16'(want.clock_out), 16'(clock_out));
        check_field("buttons", 16'(want.buttons), 16'(buttons));
        check_field("fresh", 16'(want.fresh), 16'(fresh));
      end
      last_btn = buttons;
    end
  end

  initial begin : stim
    dir_row_t row;
    int       first_items;
    int       n_phase;
    int       k;
    seq_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_tab[i];
      case (row.kind)
        ROW_CFG:  write_reg(row.a[CFG_IDX_W-1:0], row.b[CFG_W-1:0]);
        ROW_POLL: run_poll(row.a[BITS_PER_READ-1:0], row.b[0]);
        default:  repeat (row.a) send_tick(row.b[0]);
      endcase
      if (row.want >= 0) begin
        drain();
        check_field("buttons", row.want[15:0], 16'(last_btn));
      end
    end

    first_items = n_items;
    n_phase     = 0;
    while ((n_items - first_items) < RAND_ITEMS) begin
      n_phase++;
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) begin
        write_reg(REG_HALF_PERIOD, CFG_W'($urandom_range(4, 12)));
      end else begin
        write_reg(REG_HALF_PERIOD, CFG_W'($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 9) == 0 && n_phase != 3) begin
        // interval too long to ever poll: block just counts
        write_reg(REG_POLL_INTERVAL, '1);
        run_noise($urandom_range(5, 40));
      end else begin
        write_reg(REG_POLL_INTERVAL, CFG_W'($urandom_range(0, 40)));
        if (n_phase == 3) begin
          // back up the output buffer so in_stall has to rise
          no_idle  = 1'b1;
          hold_req = 1'b1;
        end
        k = $urandom_range(1, 3);
        repeat (k) begin
          if ($urandom_range(0, 5) == 0) begin
            run_noise($urandom_range(5, 60));
          end else begin
            run_poll(16'($urandom), $urandom_range(0, 5) != 0);
          end
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errs == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/gsp_pkg.sv
rtl/gsp_sequencer.sv
rtl/gsp_out_buf.sv
rtl/gamepad_serial_poller.sv
bench/tb_gamepad_serial_poller.sv
